// File: rtl/mmcs_pkg.sv
package mmcs_pkg;

    // Width of the raw sensor samples that take part in the stretch.
    localparam int PIX_BITS  = 16;
    // Width of the display grey level and of the quotient.
    localparam int DISP_BITS = 8;
    // Bits of the dividend 255 * (p - min).
    localparam int NUM_BITS  = PIX_BITS + DISP_BITS;
    // Division step counter width.
    localparam int CNT_W     = $clog2(DISP_BITS);
    // Depth of the queue between the front and the divider.
    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    // Item function codes.
    localparam logic FUNC_MEASURE = 1'b0;
    localparam logic FUNC_SCALE   = 1'b1;

    // One input beat.
    typedef struct packed {
        logic        func;
        logic [15:0] pixel;
        logic        first;
        logic        last;
    } t_in;

    // One result beat.
    typedef struct packed {
        logic [7:0] display_value;
        logic       frame_end;
    } t_out;

    // How a scale item is finished by the back end.
    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_FULL,
        CLS_DIV
    } t_cls;

    // Queue entry from the front to the divider.
    typedef struct packed {
        t_cls                cls;
        logic [PIX_BITS-1:0] offset;
        logic [PIX_BITS-1:0] span;
        logic                last;
    } t_qent;

    // Divider sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_bstate;

endpackage

// File: rtl/mmcs_front.sv
module mmcs_front
    import mmcs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  push,
    output logic  full,
    input  t_in   i_item,
    input  logic  i_q_full,
    output logic  o_q_push,
    output t_qent o_q_data
);

    logic                r_accept_meas;
    logic [PIX_BITS-1:0] r_min;
    logic [PIX_BITS-1:0] r_max;
    logic [PIX_BITS-1:0] n_min;
    logic [PIX_BITS-1:0] n_max;
    logic [PIX_BITS-1:0] pix;
    logic                accept;
    logic                meas;

    assign full   = i_q_full;
    assign accept = push && !i_q_full;
    assign pix    = i_item.pixel[PIX_BITS-1:0];
    assign meas   = accept && (i_item.func == FUNC_MEASURE);

    // Running minimum and maximum; a first flag restarts them at this pixel.
    always_comb begin
        n_min = r_min;
        n_max = r_max;
        if (meas) begin
            if (i_item.first) begin
                n_min = pix;
                n_max = pix;
            end else begin
                if (pix < r_min) begin
                    n_min = pix;
                end
                if (pix > r_max) begin
                    n_max = pix;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min         <= '1;
            r_max         <= '0;
            r_accept_meas <= 1'b0;
        end else begin
            r_min         <= n_min;
            r_max         <= n_max;
            r_accept_meas <= meas;
        end
    end

    // Classify a scale item against the range latched so far.
    always_comb begin
        o_q_push        = accept && (i_item.func == FUNC_SCALE);
        o_q_data.offset = pix - r_min;
        o_q_data.span   = r_max - r_min;
        o_q_data.last   = i_item.last;
        if (r_max <= r_min || pix <= r_min) begin
            o_q_data.cls = CLS_ZERO;
        end else if (pix >= r_max) begin
            o_q_data.cls = CLS_FULL;
        end else begin
            o_q_data.cls = CLS_DIV;
        end
    end

    // After any measured sample the range is never inverted.
    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_accept_meas |-> (r_min <= r_max))
        else $error("running range inverted after a measure beat");

endmodule

// File: rtl/mmcs_fifo.sv
module mmcs_fifo
    import mmcs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_qent o_data
);

    t_qent           r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slot[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == Q_AW'(Q_DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == Q_AW'(Q_DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue fill count beyond depth");

endmodule

// File: rtl/mmcs_back.sv
module mmcs_back
    import mmcs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_empty,
    input  t_qent i_q_data,
    output logic  o_q_pop,
    input  logic  pop,
    output logic  empty,
    output t_out  o_result
);

    t_bstate              r_state;
    t_bstate              n_state;
    logic [PIX_BITS-1:0]  r_rem;
    logic [PIX_BITS-1:0]  r_den;
    logic [DISP_BITS-1:0] r_q;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_last;
    logic                 r_out_valid;
    t_out                 r_out;
    logic                 out_load;
    logic [NUM_BITS-1:0]  num;
    logic [PIX_BITS:0]    trial;
    logic [PIX_BITS:0]    diff;
    logic                 ge;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_q_data.cls == CLS_DIV) ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(DISP_BITS-1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_q_pop  = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE:  o_q_pop  = !i_q_empty;
            S_DONE:  out_load = !r_out_valid || pop;
            default: begin
                o_q_pop  = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Dividend 255 * offset, formed as offset * 256 - offset.
    assign num = {i_q_data.offset, {DISP_BITS{1'b0}}}
                 - {{DISP_BITS{1'b0}}, i_q_data.offset};

    // One restoring division step: bring down the next dividend bit.
    assign trial = {r_rem, r_q[DISP_BITS-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    // Divider datapath. The quotient is below 256, so the upper dividend
    // bits already sit below the divisor and only the low bits are walked.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rem  <= num[NUM_BITS-1:DISP_BITS];
            r_den  <= i_q_data.span;
            r_last <= i_q_data.last;
            r_cnt  <= '0;
            case (i_q_data.cls)
                CLS_DIV:  r_q <= num[DISP_BITS-1:0];
                CLS_FULL: r_q <= '1;
                default:  r_q <= '0;
            endcase
        end else if (r_state == S_DIV) begin
            r_rem <= ge ? diff[PIX_BITS-1:0] : trial[PIX_BITS-1:0];
            r_q   <= {r_q[DISP_BITS-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Output register: the finished beat waits here for the receiver.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.display_value <= r_q;
            r_out.frame_end     <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign empty    = !r_out_valid;
    assign o_result = r_out;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("partial remainder not below divisor");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_den != '0))
        else $error("division started with a zero span");

    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("loaded result not shown");

endmodule

// File: rtl/min_max_contrast_stretch.sv
// Min/max contrast stretch for 16-bit thermal frames.
// Input channel: push/full with beat i_item. A measure beat (func = 0)
// folds its pixel into the running minimum and maximum; first = 1
// restarts both at that pixel. A scale beat (func = 1) produces one
// result: floor(255 * (p - min) / (max - min)), 0 for a flat or empty
// range or p at or below min, 255 for p at or above max, with last
// copied to frame_end. Measure beats produce no result.
// Result channel: empty/pop with beat o_result, held while empty is low.
// Any beat is taken in the cycle it is offered while full is low. Scale
// beats go through a two-entry queue to a restoring divider that retires
// one quotient bit per cycle. A beat that needs the division passes
// the back end as one load, eight division steps and one writeback; a
// beat that clamps to 0 or 255 has only the load and the writeback. The
// back end loads the next queued beat only after the last one is written
// back, while the queue goes on taking scale beats until it is full.
// The range is sampled when the scale beat is taken, so later measure
// beats do not disturb it. A stalled receiver backs up the output
// register, then the queue, and then full rises for every beat.
// Reset empties the queue and the output and sets the range to
// min = all ones, max = 0.
module min_max_contrast_stretch
    import mmcs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_out o_result
);

    logic  q_full;
    logic  q_push;
    t_qent q_wdata;
    logic  q_empty;
    logic  q_pop;
    t_qent q_rdata;

    // Front: range tracking and classification.
    mmcs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    // Queue between front and divider.
    mmcs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    // Back: bit-serial divider and output register.
    mmcs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .pop       (pop),
        .empty     (empty),
        .o_result  (o_result)
    );

endmodule
